// ----- rtl/cdc_pkg.sv -----
// Shared types, constants and helpers for the cup dispense channel controller.
// No dependencies; every other file in rtl/ imports this package.
package cdc_pkg;

  // Channel count and fixed field widths
  localparam int CHANNELS  = 3;
  localparam int SENSE_W   = 3;
  localparam int PHASE_W   = 14;
  localparam int PHASE_CH  = PHASE_W / 2;
  localparam int CNT_W     = 8;
  localparam int CFG_AW    = 5;
  localparam int CFG_DW    = 32;

  // Register reset values
  localparam logic [CNT_W-1:0] WAIT_TIMEOUT_RST    = 8'd22;
  localparam logic [CNT_W-1:0] WATER_CONFIRM_RST   = 8'd28;
  localparam logic [CNT_W-1:0] PLACE_CONFIRM_RST   = 8'd3;
  localparam logic [CNT_W-1:0] REMOVAL_CONFIRM_RST = 8'd5;
  localparam logic [CNT_W-1:0] POST_DRAW_TICKS_RST = 8'd6;

  // Register index codes (byte address / 4)
  typedef enum logic [2:0] {
    REG_WAIT_TIMEOUT    = 3'd0,
    REG_WATER_CONFIRM   = 3'd1,
    REG_PLACE_CONFIRM   = 3'd2,
    REG_REMOVAL_CONFIRM = 3'd3,
    REG_POST_DRAW_TICKS = 3'd4
  } reg_idx_t;

  // Channel phase
  typedef enum logic [1:0] {
    PH_WAIT = 2'd0,
    PH_RUN  = 2'd1,
    PH_END  = 2'd2,
    PH_POST = 2'd3
  } phase_t;

  // Configuration seen by every channel
  typedef struct packed {
    logic [CNT_W-1:0] wait_timeout;
    logic [CNT_W-1:0] water_confirm;
    logic [CNT_W-1:0] place_confirm;
    logic [CNT_W-1:0] removal_confirm;
    logic [CNT_W-1:0] post_draw_ticks;
  } cfg_t;

  // Per-channel result of one tick
  typedef struct packed {
    logic   dispense;
    logic   red;
    logic   green;
    logic   ended;
    phase_t phase;
  } chan_out_t;

  // Input beat
  typedef struct packed {
    logic [SENSE_W-1:0] cup_sensed;
    logic [SENSE_W-1:0] liquid_sensed;
  } in_beat_t;

  // Result beat
  typedef struct packed {
    logic [SENSE_W-1:0] dispense_on;
    logic [SENSE_W-1:0] red_lamp;
    logic [SENSE_W-1:0] green_lamp;
    logic [SENSE_W-1:0] pump_stop;
    logic [SENSE_W-1:0] drain_pulse;
    logic [PHASE_W-1:0] phase_out;
  } out_beat_t;

  // Saturating increment of an 8-bit counter
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
  endfunction

endpackage

// ----- rtl/cdc_cfg_regs.sv -----
// Configuration register bank with an APB-style slave port.
// Depends on cdc_pkg for register codes, widths and reset values.
module cdc_cfg_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [cdc_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [cdc_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [cdc_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                       cfg_pready,
  output cdc_pkg::cfg_t              cfg
);
  import cdc_pkg::*;

  cfg_t     cfg_r;
  logic     wr_en;
  reg_idx_t idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign idx        = reg_idx_t'(cfg_paddr[CFG_AW-1:2]);
  assign cfg        = cfg_r;

  // Write the addressed register in the access phase; drop unknown addresses
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wait_timeout    <= WAIT_TIMEOUT_RST;
      cfg_r.water_confirm   <= WATER_CONFIRM_RST;
      cfg_r.place_confirm   <= PLACE_CONFIRM_RST;
      cfg_r.removal_confirm <= REMOVAL_CONFIRM_RST;
      cfg_r.post_draw_ticks <= POST_DRAW_TICKS_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_WAIT_TIMEOUT:    cfg_r.wait_timeout    <= cfg_pwdata[CNT_W-1:0];
        REG_WATER_CONFIRM:   cfg_r.water_confirm   <= cfg_pwdata[CNT_W-1:0];
        REG_PLACE_CONFIRM:   cfg_r.place_confirm   <= cfg_pwdata[CNT_W-1:0];
        REG_REMOVAL_CONFIRM: cfg_r.removal_confirm <= cfg_pwdata[CNT_W-1:0];
        REG_POST_DRAW_TICKS: cfg_r.post_draw_ticks <= cfg_pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (idx)
      REG_WAIT_TIMEOUT:    cfg_prdata = CFG_DW'(cfg_r.wait_timeout);
      REG_WATER_CONFIRM:   cfg_prdata = CFG_DW'(cfg_r.water_confirm);
      REG_PLACE_CONFIRM:   cfg_prdata = CFG_DW'(cfg_r.place_confirm);
      REG_REMOVAL_CONFIRM: cfg_prdata = CFG_DW'(cfg_r.removal_confirm);
      REG_POST_DRAW_TICKS: cfg_prdata = CFG_DW'(cfg_r.post_draw_ticks);
      default:             cfg_prdata = '0;
    endcase
  end

endmodule

// ----- rtl/cdc_channel.sv -----
// One dispensing channel: phase state, qualifying counters and lamp state,
// advanced once per accepted tick. Depends on cdc_pkg.
module cdc_channel (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               tick,
  input  logic               cup,
  input  logic               liq,
  input  cdc_pkg::cfg_t      cfg,
  output cdc_pkg::chan_out_t res
);
  import cdc_pkg::*;

  phase_t           phase_r, phase_nxt;
  logic [CNT_W-1:0] scan_r, scan_nxt;
  logic [CNT_W-1:0] liq_cnt_r, liq_cnt_nxt;
  logic [CNT_W-1:0] place_cnt_r, place_cnt_nxt;
  logic [CNT_W-1:0] rem_cnt_r, rem_cnt_nxt;
  logic             tflag_r, tflag_nxt;
  logic             liq_ok_r, liq_ok_nxt;
  logic             red_r, red_nxt;
  logic             green_r, green_nxt;
  logic             disp_r, disp_nxt;
  logic             ended, stop;

  // Hold state between ticks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_WAIT;
      scan_r      <= '0;
      liq_cnt_r   <= '0;
      place_cnt_r <= '0;
      rem_cnt_r   <= '0;
      tflag_r     <= 1'b0;
      liq_ok_r    <= 1'b1;
      red_r       <= 1'b0;
      green_r     <= 1'b0;
      disp_r      <= 1'b0;
    end else if (tick) begin
      phase_r     <= phase_nxt;
      scan_r      <= scan_nxt;
      liq_cnt_r   <= liq_cnt_nxt;
      place_cnt_r <= place_cnt_nxt;
      rem_cnt_r   <= rem_cnt_nxt;
      tflag_r     <= tflag_nxt;
      liq_ok_r    <= liq_ok_nxt;
      red_r       <= red_nxt;
      green_r     <= green_nxt;
      disp_r      <= disp_nxt;
    end
  end

  // One tick: phases cascade waiting -> running -> ending -> post-draw
  always_comb begin
    phase_nxt     = phase_r;
    scan_nxt      = sat_inc(scan_r);
    liq_cnt_nxt   = liq_cnt_r;
    place_cnt_nxt = place_cnt_r;
    rem_cnt_nxt   = rem_cnt_r;
    tflag_nxt     = tflag_r;
    liq_ok_nxt    = liq_ok_r;
    red_nxt       = red_r;
    green_nxt     = green_r;
    disp_nxt      = disp_r;
    ended         = 1'b0;
    stop          = 1'b0;

    // Waiting: qualify cup placement
    if (phase_nxt == PH_WAIT) begin
      green_nxt = 1'b1;
      if (cup) begin
        place_cnt_nxt = sat_inc(place_cnt_nxt);
        if (place_cnt_nxt >= cfg.place_confirm) begin
          place_cnt_nxt = '0;
          phase_nxt     = PH_RUN;
          green_nxt     = 1'b0;
          scan_nxt      = '0;
          tflag_nxt     = 1'b0;
        end
      end
    end

    // Running: periodic timeout, liquid loss, removal
    if (phase_nxt == PH_RUN) begin
      red_nxt  = 1'b1;
      disp_nxt = 1'b1;
      if (scan_nxt >= cfg.wait_timeout && !tflag_nxt) begin
        scan_nxt  = '0;
        tflag_nxt = 1'b1;
      end
      if (!liq) begin
        liq_cnt_nxt = sat_inc(liq_cnt_nxt);
        if (liq_cnt_nxt >= cfg.water_confirm) begin
          liq_ok_nxt  = 1'b0;
          liq_cnt_nxt = '0;
        end
      end else begin
        liq_ok_nxt  = 1'b1;
        liq_cnt_nxt = '0;
      end
      stop = !liq_ok_nxt && tflag_nxt;
      // removal is only checked when liquid loss has not ended the run
      if (!stop && !cup) begin
        rem_cnt_nxt = sat_inc(rem_cnt_nxt);
        if (rem_cnt_nxt >= cfg.removal_confirm) begin
          rem_cnt_nxt = '0;
          stop        = 1'b1;
        end
      end
      if (stop) begin
        tflag_nxt = 1'b1;
        phase_nxt = PH_END;
        red_nxt   = 1'b0;
        disp_nxt  = 1'b0;
        ended     = 1'b1;
      end else begin
        tflag_nxt = 1'b0;
      end
    end

    // Ending: flash lamps until removal is confirmed
    if (phase_nxt == PH_END) begin
      tflag_nxt = 1'b0;
      red_nxt   = ~red_nxt;
      green_nxt = ~green_nxt;
      if (!cup) begin
        rem_cnt_nxt = sat_inc(rem_cnt_nxt);
        if (rem_cnt_nxt >= cfg.removal_confirm) begin
          rem_cnt_nxt = '0;
          phase_nxt   = PH_POST;
          red_nxt     = 1'b0;
          green_nxt   = 1'b0;
          scan_nxt    = '0;
        end
      end
    end

    // Post-draw: keep dispensing for a set number of ticks
    if (phase_nxt == PH_POST) begin
      if (scan_nxt <= cfg.post_draw_ticks) begin
        red_nxt  = ~red_nxt;
        disp_nxt = 1'b1;
      end else begin
        red_nxt   = 1'b0;
        green_nxt = 1'b0;
        disp_nxt  = 1'b0;
        phase_nxt = PH_WAIT;
        scan_nxt  = '0;
      end
    end
  end

  assign res.dispense = disp_nxt;
  assign res.red      = red_nxt;
  assign res.green    = green_nxt;
  assign res.ended    = ended;
  assign res.phase    = phase_nxt;

endmodule

// ----- rtl/cup_dispense_channel_controller_unit.sv -----
// Top level of the cup dispense channel controller: channels, register bank
// and result register. Depends on cdc_pkg, cdc_cfg_regs and cdc_channel.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data): one beat is one scan tick
//   holding the cup and liquid sensor bits of every channel.
//   Result channel (out_valid / out_stall / out_data): one beat per tick with
//   dispense, lamp, pump-stop and drain requests and the phase of each channel.
//   Configuration: APB-style port, register i at byte address 4*i, pready
//   always high; write only while no tick is in flight.
// Result timing: the result of a tick is registered and appears in out_data in
//   the cycle after its input beat is accepted.
// Throughput: one tick per cycle while in_stall is low; each channel's update
//   is a single pass of shallow compare-and-count logic into the result register.
// Reset: rst_n is synchronous, active low; all channels return to waiting
//   with counters cleared, lamps off and the registers at their defaults.
// Stall: a waiting result is held in the result register while out_stall is
//   high; a new tick is still taken in the cycle an old result is read out,
//   and in_stall is raised only while a waiting result is being stalled.
module cup_dispense_channel_controller_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  cdc_pkg::in_beat_t          in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output cdc_pkg::out_beat_t         out_data,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [cdc_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [cdc_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [cdc_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                       cfg_pready
);
  import cdc_pkg::*;

  cfg_t      cfg;
  chan_out_t ch_res [CHANNELS];
  logic      tick;
  out_beat_t res_nxt;
  out_beat_t out_data_r;
  logic      out_valid_r;

  // Register bank
  cdc_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // Accept a beat whenever the result register is free or draining
  assign in_stall = out_valid_r & out_stall;
  assign tick     = in_valid & ~in_stall;

  // Channels; those beyond the sensor width read zero
  for (genvar c = 0; c < CHANNELS; c++) begin : g_ch
    logic cup_b, liq_b;
    if (c < SENSE_W) begin : g_sense
      assign cup_b = in_data.cup_sensed[c];
      assign liq_b = in_data.liquid_sensed[c];
    end else begin : g_nosense
      assign cup_b = 1'b0;
      assign liq_b = 1'b0;
    end
    cdc_channel u_ch (
      .clk   (clk),
      .rst_n (rst_n),
      .tick  (tick),
      .cup   (cup_b),
      .liq   (liq_b),
      .cfg   (cfg),
      .res   (ch_res[c])
    );
  end

  // Gather per-channel results into one beat
  always_comb begin
    res_nxt = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      if (c < SENSE_W) begin
        res_nxt.dispense_on[c] = ch_res[c].dispense;
        res_nxt.red_lamp[c]    = ch_res[c].red;
        res_nxt.green_lamp[c]  = ch_res[c].green;
        res_nxt.pump_stop[c]   = ch_res[c].ended;
        res_nxt.drain_pulse[c] = ch_res[c].ended;
      end
      if (c < PHASE_CH) begin
        res_nxt.phase_out[2*c +: 2] = ch_res[c].phase;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (tick) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // An accepted tick always leaves a result behind
  a_tick_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    tick |=> out_valid)
    else $error("accepted tick produced no result");

  // A run on channel 0 that ends this tick is left in ending or post-draw
  a_stop_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.pump_stop[0] |->
      (out_data.phase_out[1:0] == PH_END) || (out_data.phase_out[1:0] == PH_POST))
    else $error("pump stop without ending phase");

  // Running on channel 0 shows red, dispenses and keeps green dark
  a_run_outputs: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.phase_out[1:0] == PH_RUN) |->
      out_data.dispense_on[0] && out_data.red_lamp[0] && !out_data.green_lamp[0])
    else $error("running channel outputs wrong");

  // Post-draw on channel 0 never lights green
  a_post_green: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.phase_out[1:0] == PH_POST) |-> !out_data.green_lamp[0])
    else $error("green lamp lit in post-draw");
`endif

endmodule

// ----- bench/tb_cup_dispense_channel_controller_unit.sv -----
// Self-checking bench for the cup dispense channel controller: scan ticks in, one
// predicted result beat per tick compared field by field. Needs cdc_pkg and the RTL.
`timescale 1ns / 1ps

module tb_cup_dispense_channel_controller_unit;
  import cdc_pkg::*;

  localparam logic [1:0] LAMP_RED   = 2'b01;
  localparam logic [1:0] LAMP_GREEN = 2'b10;
  localparam logic [2:0] SPARE_REG_A = 3'd5;
  localparam logic [2:0] SPARE_REG_B = 3'd7;
  localparam logic [CNT_W-1:0] CNT_MAX = 8'hFF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_beat_t out_data;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [CFG_DW-1:0] cfg_pwdata = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic cfg_pready;

  cup_dispense_channel_controller_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Channel state mirrored by the predictor
  cfg_t             cur_cfg;
  phase_t           ch_phase     [CHANNELS];
  logic [CNT_W-1:0] scan_cnt     [CHANNELS];
  logic             timeout_seen [CHANNELS];
  logic [CNT_W-1:0] dry_cnt      [CHANNELS];
  logic             liquid_ok    [CHANNELS];
  logic [CNT_W-1:0] place_cnt    [CHANNELS];
  logic [CNT_W-1:0] absent_cnt   [CHANNELS];
  logic [1:0]       lamps        [CHANNELS];
  logic             dispensing   [CHANNELS];

  out_beat_t expected_beats[$];
  int mismatches = 0;
  int ticks_sent = 0;
  int beats_checked = 0;
  int runs_ended = 0;
  int settings_used = 1;

  // Idling controls
  bit send_gaps_on = 1'b1;
  bit stall_bursts_on = 1'b1;
  int hold_off_left = 0;
  int stall_burst_left = 0;

  // Sensor levels held between ticks so that sequences look like real cups
  logic [SENSE_W-1:0] cup_level = '0;
  logic [SENSE_W-1:0] liq_level = '1;

  function automatic logic [CNT_W-1:0] sat_bump(logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 8'd1;
  endfunction

  // Count an absent read; report a confirmed removal and clear the count
  function automatic logic removal_confirmed(int c, logic cup);
    if (cup)
      return 1'b0;
    absent_cnt[c] = sat_bump(absent_cnt[c]);
    if (absent_cnt[c] >= cur_cfg.removal_confirm) begin
      absent_cnt[c] = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Step every channel by one scan tick and build the result beat
  function automatic out_beat_t advance_channels(in_beat_t b);
    out_beat_t r;
    logic cup, liq, ended, stop_now;
    r = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      cup = b.cup_sensed[c];
      liq = b.liquid_sensed[c];
      ended = 1'b0;
      scan_cnt[c] = sat_bump(scan_cnt[c]);

      if (ch_phase[c] == PH_WAIT) begin
        lamps[c] |= LAMP_GREEN;
        if (cup) begin
          place_cnt[c] = sat_bump(place_cnt[c]);
          if (place_cnt[c] >= cur_cfg.place_confirm) begin
            place_cnt[c] = '0;
            ch_phase[c] = PH_RUN;
            lamps[c] &= ~LAMP_GREEN;
            scan_cnt[c] = '0;
            timeout_seen[c] = 1'b0;
          end
        end
      end
      if (ch_phase[c] == PH_RUN) begin
        lamps[c] |= LAMP_RED;
        dispensing[c] = 1'b1;
        if (scan_cnt[c] >= cur_cfg.wait_timeout && !timeout_seen[c]) begin
          scan_cnt[c] = '0;
          timeout_seen[c] = 1'b1;
        end
        if (!liq) begin
          dry_cnt[c] = sat_bump(dry_cnt[c]);
          if (dry_cnt[c] >= cur_cfg.water_confirm) begin
            liquid_ok[c] = 1'b0;
            dry_cnt[c] = '0;
          end
        end else begin
          liquid_ok[c] = 1'b1;
          dry_cnt[c] = '0;
        end
        // removal is only looked at when the liquid-loss check does not fire
        stop_now = !liquid_ok[c] && timeout_seen[c];
        if (!stop_now)
          stop_now = removal_confirmed(c, cup);
        if (stop_now) begin
          timeout_seen[c] = 1'b1;
          ch_phase[c] = PH_END;
          lamps[c] &= ~LAMP_RED;
          dispensing[c] = 1'b0;
          ended = 1'b1;
        end else begin
          timeout_seen[c] = 1'b0;
        end
      end
      if (ch_phase[c] == PH_END) begin
        timeout_seen[c] = 1'b0;
        lamps[c] ^= (LAMP_RED | LAMP_GREEN);
        if (removal_confirmed(c, cup)) begin
          ch_phase[c] = PH_POST;
          lamps[c] = '0;
          scan_cnt[c] = '0;
        end
      end
      if (ch_phase[c] == PH_POST) begin
        if (scan_cnt[c] <= cur_cfg.post_draw_ticks) begin
          lamps[c] ^= LAMP_RED;
          dispensing[c] = 1'b1;
        end else begin
          lamps[c] = '0;
          dispensing[c] = 1'b0;
          ch_phase[c] = PH_WAIT;
          scan_cnt[c] = '0;
        end
      end

      r.dispense_on[c] = dispensing[c];
      r.red_lamp[c] = lamps[c][0];
      r.green_lamp[c] = lamps[c][1];
      r.pump_stop[c] = ended;
      r.drain_pulse[c] = ended;
      r.phase_out[2*c +: 2] = ch_phase[c];
    end
    return r;
  endfunction

  task automatic restore_defaults();
    cur_cfg.wait_timeout = WAIT_TIMEOUT_RST;
    cur_cfg.water_confirm = WATER_CONFIRM_RST;
    cur_cfg.place_confirm = PLACE_CONFIRM_RST;
    cur_cfg.removal_confirm = REMOVAL_CONFIRM_RST;
    cur_cfg.post_draw_ticks = POST_DRAW_TICKS_RST;
    for (int c = 0; c < CHANNELS; c++) begin
      ch_phase[c] = PH_WAIT;
      scan_cnt[c] = '0;
      timeout_seen[c] = 1'b0;
      dry_cnt[c] = '0;
      liquid_ok[c] = 1'b1;
      place_cnt[c] = '0;
      absent_cnt[c] = '0;
      lamps[c] = '0;
      dispensing[c] = 1'b0;
    end
  endtask

  // Predict each accepted tick
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      expected_beats.push_back(advance_channels(in_data));
      ticks_sent++;
    end
  end

  task automatic check_field(string field, logic [PHASE_W-1:0] want,
                             logic [PHASE_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t ns: %s expected %h, actual %h", $time, field, want, got);
    end
  endtask

  // Compare each result beat with the oldest prediction
  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_beats.size() == 0) begin
        mismatches++;
        $display("%0t ns: result beat with none expected, expected nothing, actual %h",
                 $time, out_data);
      end else begin
        want = expected_beats.pop_front();
        beats_checked++;
        runs_ended += $countones(want.pump_stop);
        check_field("dispense_on", PHASE_W'(want.dispense_on),
                    PHASE_W'(out_data.dispense_on));
        check_field("red_lamp", PHASE_W'(want.red_lamp), PHASE_W'(out_data.red_lamp));
        check_field("green_lamp", PHASE_W'(want.green_lamp),
                    PHASE_W'(out_data.green_lamp));
        check_field("pump_stop", PHASE_W'(want.pump_stop), PHASE_W'(out_data.pump_stop));
        check_field("drain_pulse", PHASE_W'(want.drain_pulse),
                    PHASE_W'(out_data.drain_pulse));
        check_field("phase_out", want.phase_out, out_data.phase_out);
      end
    end
  end

  // Result side: long hold-off when asked, else random stall bursts
  always @(posedge clk) begin
    if (hold_off_left > 0) begin
      out_stall <= 1'b1;
      hold_off_left--;
    end else if (stall_burst_left > 0) begin
      out_stall <= 1'b1;
      stall_burst_left--;
    end else if (stall_bursts_on && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_burst_left = $urandom_range(0, 5);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Offer one tick, maybe after a gap, and hold it until accepted
  task automatic send_tick(in_beat_t b);
    if (send_gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_levels(logic [SENSE_W-1:0] cup, logic [SENSE_W-1:0] liq, int n);
    in_beat_t b;
    b.cup_sensed = cup;
    b.liquid_sensed = liq;
    repeat (n) send_tick(b);
  endtask

  // Drop valid and wait for every prediction to be met, plus the pipeline tail
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Register write (setup, access), then read it back if it is a known register
  task automatic reg_write(logic [2:0] idx, logic [CNT_W-1:0] value);
    logic [CFG_DW-1:0] readback;
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= CFG_DW'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (idx)
      REG_WAIT_TIMEOUT:    cur_cfg.wait_timeout = value;
      REG_WATER_CONFIRM:   cur_cfg.water_confirm = value;
      REG_PLACE_CONFIRM:   cur_cfg.place_confirm = value;
      REG_REMOVAL_CONFIRM: cur_cfg.removal_confirm = value;
      REG_POST_DRAW_TICKS: cur_cfg.post_draw_ticks = value;
      default: ;
    endcase
    if (idx <= REG_POST_DRAW_TICKS) begin
      cfg_penable <= 1'b0;
      cfg_pwrite <= 1'b0;
      @(posedge clk);
      cfg_penable <= 1'b1;
      @(posedge clk);
      while (!cfg_pready) @(posedge clk);
      readback = cfg_prdata;
      check_field("register readback", PHASE_W'(value), PHASE_W'(readback));
    end
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(logic [CNT_W-1:0] wt, logic [CNT_W-1:0] wc,
                                logic [CNT_W-1:0] pc, logic [CNT_W-1:0] rc,
                                logic [CNT_W-1:0] pd);
    settle();
    reg_write(REG_WAIT_TIMEOUT, wt);
    reg_write(REG_WATER_CONFIRM, wc);
    reg_write(REG_PLACE_CONFIRM, pc);
    reg_write(REG_REMOVAL_CONFIRM, rc);
    reg_write(REG_POST_DRAW_TICKS, pd);
    settings_used++;
  endtask

  // Mostly held sensor levels with random flips; now and then pure noise
  task automatic send_sequences(int n, int cup_flip, int liq_flip);
    in_beat_t b;
    repeat (n) begin
      for (int c = 0; c < SENSE_W; c++) begin
        if ($urandom_range(1, cup_flip) == 1) cup_level[c] = ~cup_level[c];
        if ($urandom_range(1, liq_flip) == 1) liq_level[c] = ~liq_level[c];
      end
      if ($urandom_range(0, 11) == 0) begin
        b.cup_sensed = SENSE_W'($urandom_range(0, 7));
        b.liquid_sensed = SENSE_W'($urandom_range(0, 7));
      end else begin
        b.cup_sensed = cup_level;
        b.liquid_sensed = liq_level;
      end
      send_tick(b);
    end
  endtask

  // Place, run, remove, post-draw and back to waiting at reset settings
  task automatic test_directed_cycle();
    send_levels(3'b000, 3'b000, 1);
    send_levels(3'b111, 3'b111, 3);
    send_levels(3'b101, 3'b010, 1);
    send_levels(3'b000, 3'b111, 9);
    send_levels(3'b000, 3'b000, 8);
  endtask

  // Writes to unmapped indexes must leave the settings alone
  task automatic test_spare_registers();
    settle();
    reg_write(SPARE_REG_A, CNT_W'($urandom_range(0, 255)));
    reg_write(SPARE_REG_B, CNT_W'($urandom_range(0, 255)));
    send_sequences(40, 6, 10);
  endtask

  task automatic test_reset_settings();
    send_sequences(250, 30, 40);
  endtask

  // Zero thresholds are met at once
  task automatic test_zero_thresholds();
    apply_settings(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    send_sequences(150, 4, 4);
  endtask

  task automatic test_min_thresholds();
    apply_settings(8'd1, 8'd1, 8'd1, 8'd1, 8'd0);
    send_sequences(200, 5, 6);
  endtask

  // Top thresholds; long waits also saturate the counters
  task automatic test_max_thresholds();
    apply_settings(8'd255, 8'd255, 8'd255, 8'd255, 8'd254);
    send_sequences(350, 200, 300);
  endtask

  task automatic test_random_settings();
    repeat (3) begin
      apply_settings(CNT_W'($urandom_range(0, 40)), CNT_W'($urandom_range(0, 40)),
                     CNT_W'($urandom_range(0, 8)), CNT_W'($urandom_range(0, 10)),
                     CNT_W'($urandom_range(0, 255)));
      send_sequences(120, $urandom_range(4, 40), $urandom_range(4, 40));
    end
  endtask

  // Hold the result side off long enough to back the block up
  task automatic test_backpressure();
    apply_settings(8'd6, 8'd4, 8'd2, 8'd3, 8'd5);
    send_gaps_on = 1'b0;
    hold_off_left = 60;
    send_sequences(120, 8, 8);
    send_gaps_on = 1'b1;
  endtask

  // Back-to-back ticks with no stalls at reset values
  task automatic test_steady_stream();
    apply_settings(WAIT_TIMEOUT_RST, WATER_CONFIRM_RST, PLACE_CONFIRM_RST,
                   REMOVAL_CONFIRM_RST, POST_DRAW_TICKS_RST);
    send_gaps_on = 1'b0;
    stall_bursts_on = 1'b0;
    send_sequences(100, 10, 12);
  endtask

  initial begin
    restore_defaults();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cycle();
    test_spare_registers();
    test_reset_settings();
    test_zero_thresholds();
    test_min_thresholds();
    test_max_thresholds();
    test_random_settings();
    test_backpressure();
    test_steady_stream();
    settle();

    $display("Run covered %0d scan ticks and %0d result beats over %0d register settings,",
             ticks_sent, beats_checked, settings_used);
    $display("with %0d channel runs ended by removal or liquid loss.", runs_ended);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
